// ----- rtl/core/rtpb_pkg.sv -----
`default_nettype none

package rtpb_pkg;

  localparam int unsigned STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t S_IDLE      = 3'd0;
  localparam step_t S_FIN_CHK   = 3'd1;
  localparam step_t S_TEST      = 3'd2;
  localparam step_t S_EMIT      = 3'd3;
  localparam step_t S_MERGE     = 3'd4;
  localparam step_t S_FIN_TEST  = 3'd5;
  localparam step_t S_FLUSH     = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT,
    OP_MERGE,
    OP_FLUSH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_FIN,
    C_TOTAL_LT8,
    C_FILLED_ZERO
  } cond_t;

  typedef struct packed {
    logic  ready;
    logic  wait_out;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [2:0] FILL_MAX  = 3'h7;

  // control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{ready: 1'b0, wait_out: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (s)
      S_IDLE:     w = '{1'b1, 1'b0, OP_LOAD,  C_NO_ACCEPT,   S_IDLE};
      S_FIN_CHK:  w = '{1'b0, 1'b0, OP_NONE,  C_FIN,         S_FIN_TEST};
      S_TEST:     w = '{1'b0, 1'b0, OP_NONE,  C_TOTAL_LT8,   S_MERGE};
      S_EMIT:     w = '{1'b0, 1'b1, OP_EMIT,  C_ALWAYS,      S_TEST};
      S_MERGE:    w = '{1'b0, 1'b0, OP_MERGE, C_ALWAYS,      S_IDLE};
      S_FIN_TEST: w = '{1'b0, 1'b0, OP_NONE,  C_FILLED_ZERO, S_IDLE};
      S_FLUSH:    w = '{1'b0, 1'b1, OP_FLUSH, C_ALWAYS,      S_IDLE};
      default:    w = '{1'b0, 1'b0, OP_NONE,  C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

  // ones in the low n bit positions
  function automatic logic [7:0] low_mask(input logic [2:0] n);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/run_to_packed_bitmap.sv -----
// run_to_packed_bitmap: expands runs of equal bits into a packed byte stream
// input words on in_*: a run length and its bit value in in_tdata, a finish
// flag in in_tuser; a word is taken when in_tvalid and in_tready are high
// result words on out_*: one packed byte in out_tdata, earliest bit in bit 0,
// out_tlast high on the final byte that one input word produces
// a run with no completed byte, and a finish with no pending bits, give nothing
// a finish pads the pending partial byte with zeros, sends it and clears state
// control is a small microprogram: a step counter addresses a control store
// whose words drive the datapath and select conditional jumps
// a run passes the idle and finish check steps, then the test and emit steps
// of the byte loop per completed byte, then merge; a finish passes idle,
// finish check and finish test, then flush when it sends a byte
// in_tready is high only while the sequencer sits at its idle step
// a registered output stage holds the byte; while the receiver stalls, the
// emit or flush step waits and the sequencer holds its place, nothing is lost
// reset (rst_n low, synchronous) empties the partial byte and output stage
// and returns the sequencer to idle
`default_nettype none

module run_to_packed_bitmap #(
  parameter int unsigned RUN_LENGTH_BITS = 9
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  // run_length [RUN_LENGTH_BITS-1:0], bit_value, zero fill to whole bytes
  input  wire  [((RUN_LENGTH_BITS+1+7)/8)*8-1:0]  in_tdata,
  // finish
  input  wire                                     in_tuser,
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  // packed_byte
  output logic [7:0]                              out_tdata,
  output logic                                    out_tlast
);
  import rtpb_pkg::*;

  localparam int unsigned TOT_W = RUN_LENGTH_BITS + 1;

  // sequencer
  step_t step_r, step_nxt;
  ctrl_t ctrl;

  // datapath
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [2:0]       filled_r, filled_nxt;
  logic             bit_r, bit_nxt;
  logic             fin_r, fin_nxt;

  // output stage
  logic       ov_r, ov_nxt;
  logic [7:0] odata_r, odata_nxt;
  logic       olast_r, olast_nxt;

  logic in_acc, out_free, out_busy, cond_hit, total_lt8;
  logic [RUN_LENGTH_BITS-1:0] in_len;
  logic [7:0] fill_bits;

  assign ctrl      = ucode(step_r);
  assign in_len    = in_tdata[RUN_LENGTH_BITS-1:0];
  assign in_acc    = in_tvalid && ctrl.ready;
  assign out_free  = !ov_r || out_tready;
  assign out_busy  = !out_free;
  assign total_lt8 = (total_r < TOT_W'(8));
  // the run's bit repeated across the byte
  assign fill_bits = bit_r ? BYTE_ONES : 8'h00;

  always_comb begin
    case (ctrl.cond)
      C_NEVER:       cond_hit = 1'b0;
      C_ALWAYS:      cond_hit = 1'b1;
      C_NO_ACCEPT:   cond_hit = !in_acc;
      C_FIN:         cond_hit = fin_r;
      C_TOTAL_LT8:   cond_hit = total_lt8;
      C_FILLED_ZERO: cond_hit = (filled_r == '0);
      default:       cond_hit = 1'b1;
    endcase
  end

  // next step: hold while waiting on the output stage, else jump or advance
  always_comb begin
    if (ctrl.wait_out && out_busy) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_comb begin
    total_nxt  = total_r;
    pend_nxt   = pend_r;
    filled_nxt = filled_r;
    bit_nxt    = bit_r;
    fin_nxt    = fin_r;
    ov_nxt     = ov_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    unique case (ctrl.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        if (in_acc) begin
          bit_nxt   = in_tdata[RUN_LENGTH_BITS];
          fin_nxt   = in_tuser;
          // pending bits plus the new run, in bits
          total_nxt = TOT_W'(filled_r) + TOT_W'(in_len);
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          // pending bits low, the run's bit above them
          odata_nxt  = pend_r | (fill_bits & ~low_mask(filled_r));
          olast_nxt  = (total_r < TOT_W'(16));
          ov_nxt     = 1'b1;
          total_nxt  = total_r - TOT_W'(8);
          pend_nxt   = '0;
          filled_nxt = '0;
        end
      end
      OP_MERGE: begin
        // fewer than eight bits left: append them to the partial byte
        filled_nxt = total_r[2:0] & FILL_MAX;
        pend_nxt   = pend_r | (fill_bits & low_mask(total_r[2:0]) & ~low_mask(filled_r));
      end
      OP_FLUSH: begin
        if (out_free) begin
          odata_nxt  = pend_r;
          olast_nxt  = 1'b1;
          ov_nxt     = 1'b1;
          pend_nxt   = '0;
          filled_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= S_IDLE;
      pend_r   <= '0;
      filled_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      pend_r   <= pend_nxt;
      filled_r <= filled_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    bit_r   <= bit_nxt;
    fin_r   <= fin_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign in_tready  = ctrl.ready;
  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

`ifndef NO_ASSERTIONS
  // partial byte keeps nothing above its filled bits
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~low_mask(filled_r)) == 8'h00)
    else $error("partial byte has bits above fill count");

  // an accepted word always goes to the finish check next
  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> step_r == S_FIN_CHK)
    else $error("sequencer left idle to the wrong step");

  // merge only ever sees a remainder below one byte
  a_merge_small: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_MERGE |-> total_lt8)
    else $error("merge with a whole byte still pending");

  // the output stage is never overwritten while the receiver stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r && $stable(odata_r) && $stable(olast_r))
    else $error("stalled output byte changed");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_W         = 9;
  localparam int unsigned RANDOM_WORDS  = 144;
  localparam int unsigned SETTLE_CYCLES = 24;
  // sized from the worst case of about 170 words x 64 bytes, each byte under a long stall, taken several times
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;

  // one expected output byte, fields as on the result channel
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_of_run;
  } bitmap_byte_t;

  // shadow of the packer: keeps its own partial byte and fill count and
  // queues the bytes each accepted word must produce
  class bitmap_scoreboard;
    logic [7:0]   partial_byte;
    int unsigned  filled_bits;
    bitmap_byte_t expected_bytes[$];
    int unsigned  errors;

    function new();
      partial_byte = '0;
      filled_bits  = 0;
      errors       = 0;
    endfunction

    // expand one accepted word into the bytes it completes
    function void note_word(input logic [LEN_W-1:0] run_length, input logic bit_value,
                            input logic finish);
      bitmap_byte_t nb;
      int unsigned  produced;
      produced = 0;
      if (finish) begin
        // pad the pending bits with zeros; the run in the same word is ignored
        if (filled_bits != 0) begin
          nb.packed_byte = partial_byte >> (8 - filled_bits);
          nb.last_of_run = 1'b1;
          expected_bytes.push_back(nb);
        end
        partial_byte = '0;
        filled_bits  = 0;
      end else begin
        for (int unsigned i = 0; i < run_length; i++) begin
          // new bit enters at the top, earlier bits move down towards bit 0
          partial_byte = {bit_value, partial_byte[7:1]};
          filled_bits++;
          if (filled_bits == 8) begin
            nb.packed_byte = partial_byte;
            nb.last_of_run = 1'b0;
            expected_bytes.push_back(nb);
            produced++;
            partial_byte = '0;
            filled_bits  = 0;
          end
        end
        // mark the final byte this word produced
        if (produced > 0) begin
          nb = expected_bytes.pop_back();
          nb.last_of_run = 1'b1;
          expected_bytes.push_back(nb);
        end
      end
    endfunction

    function void check_byte(input logic [7:0] data, input logic last);
      bitmap_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        $error("out_tdata: no byte expected, got %02h (tlast %0b)", data, last);
        errors++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (data !== exp_b.packed_byte) begin
        $error("packed_byte: expected %02h, got %02h", exp_b.packed_byte, data);
        errors++;
      end
      if (last !== exp_b.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", exp_b.last_of_run, last);
        errors++;
      end
    endfunction

    function int unsigned waiting();
      return expected_bytes.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;   // run_length [8:0], bit_value [9], zero fill [15:10]
  logic             in_tuser;   // finish
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;  // packed_byte
  logic             out_tlast;  // last_of_run

  bitmap_scoreboard sb = new();
  bit               in_calm  = 1'b0;
  bit               out_calm = 1'b0;
  int unsigned      cycle_count = 0;

  run_to_packed_bitmap #(
    .RUN_LENGTH_BITS(LEN_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long; none in a calm stretch
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 7);
    return $urandom_range(10, 30);
  endfunction

  // run lengths: mostly a few bytes, some longer, a few up to the full width
  function automatic logic [LEN_W-1:0] pick_run_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(0, 24));
    if (r < 92) return LEN_W'($urandom_range(25, 100));
    return LEN_W'($urandom_range(101, 511));
  endfunction

  // drive one input word from a falling edge, hold it until taken,
  // return at the falling edge after acceptance
  task automatic send_word(input logic [LEN_W-1:0] run_length, input logic bit_value,
                           input logic finish);
    int unsigned gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, bit_value, run_length};
    in_tuser  = finish;
    do @(posedge clk); while (!in_tready);
    sb.note_word(run_length, bit_value, finish);
    @(negedge clk);
  endtask

  // result side back-pressure, changed on the falling edge
  initial begin
    int unsigned hold;
    hold = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      // at stretch boundaries pick a calm or a busy stretch at random, mostly busy
      if (cycle_count % 256 == 0) out_calm = ($urandom_range(0, 3) == 0);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 99) < 30) hold = pick_gap(out_calm);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("run_to_packed_bitmap: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty run, finish with nothing pending
    send_word(9'd0, 1'b1, 1'b0);
    send_word(9'd0, 1'b0, 1'b1);
    // exactly one byte of ones
    send_word(9'd8, 1'b1, 1'b0);
    // longest runs of both values, each leaving seven bits pending
    send_word(9'd511, 1'b1, 1'b0);
    // finish carrying a run: run ignored, pending ones padded
    send_word(9'd300, 1'b1, 1'b1);
    send_word(9'd511, 1'b0, 1'b0);
    send_word(9'd1, 1'b1, 1'b0);
    // byte assembled across runs, with an empty run in between
    send_word(9'd3, 1'b1, 1'b0);
    send_word(9'd0, 1'b0, 1'b0);
    send_word(9'd5, 1'b0, 1'b0);
    // single-bit runs alternating, bit order check
    for (int i = 0; i < 8; i++) send_word(9'd1, ~i[0], 1'b0);
    // length bit patterns
    send_word(9'd256, 1'b1, 1'b0);
    send_word(9'd170, 1'b0, 1'b0);
    send_word(9'd341, 1'b1, 1'b0);
    send_word(9'd0, 1'b1, 1'b1);
    // seven pending then padded, and one byte plus one bit then padded
    send_word(9'd7, 1'b1, 1'b0);
    send_word(9'd0, 1'b0, 1'b1);
    send_word(9'd9, 1'b0, 1'b0);
    send_word(9'd0, 1'b1, 1'b1);

    // random words: mostly runs, some finishes, content random throughout
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
      send_word(pick_run_length(), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 99) < 12));
    end
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;

    // drain, then wait out the settle time for any stray byte
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("run_to_packed_bitmap: match");
    end else begin
      $display("run_to_packed_bitmap: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/rtpb_pkg.sv
rtl/core/run_to_packed_bitmap.sv
tb/tb.sv
